// ===== rtl/core/rpap_pkg.sv =====
// Shared constants and the arctangent table for the pivot rotation pipeline.
package rpap_pkg;

    // Default sizing, handed to the top level parameters
    localparam int COORD_BITS_DEF    = 24;
    localparam int CORDIC_STAGES_DEF = 24;

    // Fixed field and number formats
    localparam int ANGLE_BITS = 18;
    localparam int FRAC_BITS  = 24;
    localparam int ZW         = 33;   // angle accumulator, degrees with 24 fractional bits
    localparam int TW         = 16;   // folded angle, 1/256 degree units

    // Angle units are 1/256 degree
    localparam int FULL_TURN    = 92160;
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;

    // Gain compensation, 1/K scaled by 2^24
    localparam int GAIN_COMP = 10188014;

    // atan(2^-i) in degrees, scaled by 2^24 and rounded
    function automatic logic [31:0] atan_q24(input int idx);
        logic [31:0] val;
        begin
            case (idx)
                0:  val = 32'd754974720;
                1:  val = 32'd445687602;
                2:  val = 32'd235489088;
                3:  val = 32'd119537938;
                4:  val = 32'd60000934;
                5:  val = 32'd30029717;
                6:  val = 32'd15018523;
                7:  val = 32'd7509720;
                8:  val = 32'd3754917;
                9:  val = 32'd1877466;
                10: val = 32'd938734;
                11: val = 32'd469367;
                12: val = 32'd234684;
                13: val = 32'd117342;
                14: val = 32'd58671;
                15: val = 32'd29335;
                16: val = 32'd14668;
                17: val = 32'd7334;
                18: val = 32'd3667;
                19: val = 32'd1833;
                20: val = 32'd917;
                21: val = 32'd458;
                22: val = 32'd229;
                23: val = 32'd115;
                24: val = 32'd57;
                25: val = 32'd29;
                26: val = 32'd14;
                27: val = 32'd7;
                28: val = 32'd4;
                29: val = 32'd2;
                30: val = 32'd1;
                default: val = 32'd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== rtl/core/rotate_point_about_pivot_top.sv =====
// Top level of the pivot rotation pipeline: stream ports, front end, CORDIC cells, back end.
//
// Rotates a point clockwise about a pivot by an angle in 1/256 degree units, using a
// pipelined CORDIC rotator with 24 fractional bits. One transaction is accepted per clock
// and one result leaves per clock while the output is not stalled. A point passes two
// front-end stages (angle fold, then gain multiply), one cell per CORDIC step and a
// saturating output register. Every stage has its own valid bit, so a stall at the
// output only holds the stages that are full and empty stages keep filling. A zero angle
// returns the point exactly; a result out of coordinate range is clamped and flagged.
module rotate_point_about_pivot_top
    import rpap_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // point_x, point_y, pivot_x, pivot_y, angle, zero pad
    input  logic [((4*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_x, out_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]            m_axis_tdata,
    // saturated
    output logic                     m_axis_tuser
);

    localparam int XW    = COORD_BITS + FRAC_BITS + 4;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam int PAD_W = OUT_W - 2*COORD_BITS;

    logic signed [COORD_BITS-1:0] point_x, point_y, pivot_x, pivot_y;
    logic signed [ANGLE_BITS-1:0] angle;
    logic signed [COORD_BITS-1:0] out_x, out_y;

    // Chain links: index 0 is the front end output, index CORDIC_STAGES the last cell
    logic                         lv [0:CORDIC_STAGES];
    logic                         lr [0:CORDIC_STAGES];
    logic signed [XW-1:0]         lx [0:CORDIC_STAGES];
    logic signed [XW-1:0]         ly [0:CORDIC_STAGES];
    logic signed [ZW-1:0]         lz [0:CORDIC_STAGES];
    logic signed [COORD_BITS-1:0] lcx [0:CORDIC_STAGES];
    logic signed [COORD_BITS-1:0] lcy [0:CORDIC_STAGES];

    // Unpack the input transaction
    assign point_x = s_axis_tdata[COORD_BITS-1:0];
    assign point_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign pivot_x = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign pivot_y = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign angle   = s_axis_tdata[4*COORD_BITS+ANGLE_BITS-1:4*COORD_BITS];

    rpap_prep #(
        .COORD_BITS (COORD_BITS),
        .XW         (XW)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_up (s_axis_tvalid),
        .ready_up (s_axis_tready),
        .point_x  (point_x),
        .point_y  (point_y),
        .pivot_x  (pivot_x),
        .pivot_y  (pivot_y),
        .angle    (angle),
        .valid_dn (lv[0]),
        .ready_dn (lr[0]),
        .x_dn     (lx[0]),
        .y_dn     (ly[0]),
        .z_dn     (lz[0]),
        .cx_dn    (lcx[0]),
        .cy_dn    (lcy[0])
    );

    // Row of CORDIC cells
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        rpap_cell #(
            .COORD_BITS (COORD_BITS),
            .XW         (XW),
            .STAGE      (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_up (lv[i]),
            .ready_up (lr[i]),
            .x_up     (lx[i]),
            .y_up     (ly[i]),
            .z_up     (lz[i]),
            .cx_up    (lcx[i]),
            .cy_up    (lcy[i]),
            .valid_dn (lv[i+1]),
            .ready_dn (lr[i+1]),
            .x_dn     (lx[i+1]),
            .y_dn     (ly[i+1]),
            .z_dn     (lz[i+1]),
            .cx_dn    (lcx[i+1]),
            .cy_dn    (lcy[i+1])
        );
    end

    rpap_out #(
        .COORD_BITS (COORD_BITS),
        .XW         (XW)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_up  (lv[CORDIC_STAGES]),
        .ready_up  (lr[CORDIC_STAGES]),
        .x_up      (lx[CORDIC_STAGES]),
        .y_up      (ly[CORDIC_STAGES]),
        .cx_up     (lcx[CORDIC_STAGES]),
        .cy_up     (lcy[CORDIC_STAGES]),
        .valid_dn  (m_axis_tvalid),
        .ready_dn  (m_axis_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .saturated (m_axis_tuser)
    );

    // Pack the result transaction
    if (PAD_W > 0)
    begin : g_pad
        assign m_axis_tdata = {{PAD_W{1'b0}}, out_y, out_x};
    end
    else
    begin : g_nopad
        assign m_axis_tdata = {out_y, out_x};
    end

    // The residual angle of the last cell is not needed
    logic unused_z;
    assign unused_z = ^lz[CORDIC_STAGES];

endmodule

// ===== rtl/core/rpap_prep.sv =====
// Front end: angle reduction and quadrant fold, then difference vector times gain compensation.
module rpap_prep
    import rpap_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int XW         = COORD_BITS_DEF + FRAC_BITS + 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_up,
    output logic                         ready_up,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] pivot_x,
    input  logic signed [COORD_BITS-1:0] pivot_y,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output logic                         valid_dn,
    input  logic                         ready_dn,
    output logic signed [XW-1:0]         x_dn,
    output logic signed [XW-1:0]         y_dn,
    output logic signed [ZW-1:0]         z_dn,
    output logic signed [COORD_BITS-1:0] cx_dn,
    output logic signed [COORD_BITS-1:0] cy_dn
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = DW + 25;

    localparam logic signed [19:0] FULL_S    = 20'(FULL_TURN);
    localparam logic signed [19:0] HALF_S    = 20'(HALF_TURN);
    localparam logic signed [19:0] QUARTER_S = 20'(QUARTER_TURN);
    localparam logic signed [24:0] GAIN_S    = 25'(GAIN_COMP);

    // Stage A registers
    logic                         a_valid_reg, a_valid_next;
    logic signed [DW-1:0]         dx_reg, dx_next;
    logic signed [DW-1:0]         dy_reg, dy_next;
    logic signed [COORD_BITS-1:0] acx_reg, acx_next;
    logic signed [COORD_BITS-1:0] acy_reg, acy_next;
    logic signed [TW-1:0]         t_reg, t_next;

    // Stage B registers
    logic                         b_valid_reg, b_valid_next;
    logic signed [XW-1:0]         x_reg, x_next;
    logic signed [XW-1:0]         y_reg, y_next;
    logic signed [ZW-1:0]         z_reg, z_next;
    logic signed [COORD_BITS-1:0] bcx_reg, bcx_next;
    logic signed [COORD_BITS-1:0] bcy_reg, bcy_next;

    logic                         a_ready, b_ready;
    logic                         a_take, b_take;
    logic signed [19:0]           n_s, r_s, h_s, f_s;
    logic                         flip;
    logic signed [DW-1:0]         ddx, ddy;
    logic signed [PW-1:0]         px_prod, py_prod;
    logic signed [31:0]           z_wide;

    // Handshake: a stage takes new data when empty or when it hands on
    assign b_ready  = !b_valid_reg || ready_dn;
    assign a_ready  = !a_valid_reg || b_ready;
    assign ready_up = a_ready;
    assign a_take   = valid_up && a_ready;
    assign b_take   = a_valid_reg && b_ready;

    // Stage A: counterclockwise angle modulo one turn, fold into a quarter turn
    always_comb
    begin
        n_s = -20'(angle);
        if (n_s < -FULL_S)
            r_s = n_s + FULL_S + FULL_S;
        else if (n_s < 20'sd0)
            r_s = n_s + FULL_S;
        else if (n_s >= FULL_S)
            r_s = n_s - FULL_S;
        else
            r_s = n_s;

        h_s = (r_s > HALF_S) ? (r_s - FULL_S) : r_s;

        flip = 1'b0;
        f_s  = h_s;
        if (h_s > QUARTER_S)
        begin
            flip = 1'b1;
            f_s  = h_s - HALF_S;
        end
        else if (h_s < -QUARTER_S)
        begin
            flip = 1'b1;
            f_s  = h_s + HALF_S;
        end

        ddx = DW'(point_x) - DW'(pivot_x);
        ddy = DW'(point_y) - DW'(pivot_y);

        // Zero angle: rotate a null vector about the point itself
        if (angle == '0)
        begin
            dx_next  = '0;
            dy_next  = '0;
            acx_next = point_x;
            acy_next = point_y;
            t_next   = '0;
        end
        else
        begin
            dx_next  = flip ? -ddx : ddx;
            dy_next  = flip ? -ddy : ddy;
            acx_next = pivot_x;
            acy_next = pivot_y;
            t_next   = f_s[TW-1:0];
        end
        a_valid_next = a_take ? 1'b1 : (b_take ? 1'b0 : a_valid_reg);
    end

    // Stage B: gain compensation and angle into accumulator format
    always_comb
    begin
        px_prod      = dx_reg * GAIN_S;
        py_prod      = dy_reg * GAIN_S;
        z_wide       = {t_reg, 16'h0000};
        x_next       = XW'(px_prod);
        y_next       = XW'(py_prod);
        z_next       = ZW'(z_wide);
        bcx_next     = acx_reg;
        bcy_next     = acy_reg;
        b_valid_next = b_take ? 1'b1 : (ready_dn ? 1'b0 : b_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            acx_reg <= acx_next;
            acy_reg <= acy_next;
            t_reg   <= t_next;
        end
        if (b_take)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            bcx_reg <= bcx_next;
            bcy_reg <= bcy_next;
        end
    end

    assign valid_dn = b_valid_reg;
    assign x_dn     = x_reg;
    assign y_dn     = y_reg;
    assign z_dn     = z_reg;
    assign cx_dn    = bcx_reg;
    assign cy_dn    = bcy_reg;

endmodule

// ===== rtl/core/rpap_cell.sv =====
// One CORDIC rotation step with its own pipeline register and handshake.
module rpap_cell
    import rpap_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int XW         = COORD_BITS_DEF + FRAC_BITS + 4,
    parameter int STAGE      = 0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_up,
    output logic                         ready_up,
    input  logic signed [XW-1:0]         x_up,
    input  logic signed [XW-1:0]         y_up,
    input  logic signed [ZW-1:0]         z_up,
    input  logic signed [COORD_BITS-1:0] cx_up,
    input  logic signed [COORD_BITS-1:0] cy_up,
    output logic                         valid_dn,
    input  logic                         ready_dn,
    output logic signed [XW-1:0]         x_dn,
    output logic signed [XW-1:0]         y_dn,
    output logic signed [ZW-1:0]         z_dn,
    output logic signed [COORD_BITS-1:0] cx_dn,
    output logic signed [COORD_BITS-1:0] cy_dn
);

    localparam logic signed [ZW-1:0] ATAN_S = ZW'(atan_q24(STAGE));

    logic                         valid_reg, valid_next;
    logic signed [XW-1:0]         x_reg, x_next;
    logic signed [XW-1:0]         y_reg, y_next;
    logic signed [ZW-1:0]         z_reg, z_next;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic signed [XW-1:0]         xs, ys;
    logic                         take;

    assign ready_up = !valid_reg || ready_dn;
    assign take     = valid_up && ready_up;

    // Micro-rotation towards zero residual angle; shifts round to minus infinity
    always_comb
    begin
        xs = x_up >>> STAGE;
        ys = y_up >>> STAGE;
        if (!z_up[ZW-1])
        begin
            x_next = x_up - ys;
            y_next = y_up + xs;
            z_next = z_up - ATAN_S;
        end
        else
        begin
            x_next = x_up + ys;
            y_next = y_up - xs;
            z_next = z_up + ATAN_S;
        end
        valid_next = take ? 1'b1 : (ready_dn ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            cx_reg <= cx_up;
            cy_reg <= cy_up;
        end
    end

    assign valid_dn = valid_reg;
    assign x_dn     = x_reg;
    assign y_dn     = y_reg;
    assign z_dn     = z_reg;
    assign cx_dn    = cx_reg;
    assign cy_dn    = cy_reg;

endmodule

// ===== rtl/core/rpap_out.sv =====
// Back end: truncate toward zero, add the pivot back, saturate, hold the result.
module rpap_out
    import rpap_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int XW         = COORD_BITS_DEF + FRAC_BITS + 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_up,
    output logic                         ready_up,
    input  logic signed [XW-1:0]         x_up,
    input  logic signed [XW-1:0]         y_up,
    input  logic signed [COORD_BITS-1:0] cx_up,
    input  logic signed [COORD_BITS-1:0] cy_up,
    output logic                         valid_dn,
    input  logic                         ready_dn,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic                         saturated
);

    localparam int IW = XW - FRAC_BITS;
    localparam int SW = IW + 1;
    localparam logic signed [SW-1:0] HI_S = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] LO_S = -HI_S - SW'(1);

    logic                         valid_reg, valid_next;
    logic signed [COORD_BITS-1:0] ox_reg, ox_next;
    logic signed [COORD_BITS-1:0] oy_reg, oy_next;
    logic                         sat_reg, sat_next;
    logic signed [XW-1:0]         ax, ay;
    logic signed [IW-1:0]         tx, ty;
    logic signed [SW-1:0]         sx, sy;
    logic                         take;

    assign ready_up = !valid_reg || ready_dn;
    assign take     = valid_up && ready_up;

    always_comb
    begin
        // Truncation toward zero works on the magnitude
        ax = x_up[XW-1] ? -x_up : x_up;
        ay = y_up[XW-1] ? -y_up : y_up;
        tx = x_up[XW-1] ? -ax[XW-1:FRAC_BITS] : ax[XW-1:FRAC_BITS];
        ty = y_up[XW-1] ? -ay[XW-1:FRAC_BITS] : ay[XW-1:FRAC_BITS];

        sx = SW'(tx) + SW'(cx_up);
        sy = SW'(ty) + SW'(cy_up);

        // Clamp each coordinate to range
        sat_next = 1'b0;
        if (sx > HI_S)
        begin
            ox_next  = HI_S[COORD_BITS-1:0];
            sat_next = 1'b1;
        end
        else if (sx < LO_S)
        begin
            ox_next  = LO_S[COORD_BITS-1:0];
            sat_next = 1'b1;
        end
        else
            ox_next = sx[COORD_BITS-1:0];

        if (sy > HI_S)
        begin
            oy_next  = HI_S[COORD_BITS-1:0];
            sat_next = 1'b1;
        end
        else if (sy < LO_S)
        begin
            oy_next  = LO_S[COORD_BITS-1:0];
            sat_next = 1'b1;
        end
        else
            oy_next = sy[COORD_BITS-1:0];

        valid_next = take ? 1'b1 : (ready_dn ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            sat_reg <= sat_next;
        end
    end

    assign valid_dn  = valid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign saturated = sat_reg;

endmodule

// ===== test/rotate_point_about_pivot_top_tb.sv =====
// Self-checking testbench for the pivot rotation pipeline: directed and random points, bit-exact prediction.
`timescale 1ns / 1ps

module rotate_point_about_pivot_top_tb
    import rpap_pkg::*;
();

    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int STAGES       = CORDIC_STAGES_DEF;
    localparam int IN_W         = ((4*COORD_W+ANGLE_BITS+7)/8)*8;
    localparam int OUT_W        = ((2*COORD_W+7)/8)*8;
    localparam int LATENCY      = STAGES + 3;
    localparam int RANDOM_ITEMS = 1730;
    localparam int CALM_FROM    = 1480;   // no idling on either side from here on
    localparam longint C_MAX    = (longint'(1) <<< (COORD_W-1)) - 1;
    localparam longint C_MIN    = -C_MAX - 1;

    // atan(2^-i) in degrees, 24 fractional bits
    localparam longint ATAN_Q24 [0:31] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    typedef logic signed [COORD_W-1:0]    coord_t;
    typedef logic signed [ANGLE_BITS-1:0] angle_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   sat;
    } rot_result_t;

    typedef enum {MIX_WIDE, MIX_NEAR, MIX_ZERO, MIX_SPECIAL, MIX_EDGE} point_mix_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;

    // Expected rotations, oldest first
    class rotation_scoreboard;
        rot_result_t expected_q[$];
        int unsigned mismatches;
        int unsigned compared;
        int unsigned points;
        int unsigned zero_turns;
        int unsigned clamped;

        function longint toward_zero(longint v);
            return (v >= 0) ? (v >>> FRAC_BITS) : -((-v) >>> FRAC_BITS);
        endfunction

        // Clockwise turn of (p - c) by ang, truncated, pivot added back, saturated
        function rot_result_t rotate_about_pivot(coord_t px, coord_t py, coord_t cx,
                                                 coord_t cy, angle_t ang);
            rot_result_t r;
            longint t, x, y, z, xs, ys, sx, sy;
            r.sat = 1'b0;
            if (ang == 0)
            begin
                r.x = px;
                r.y = py;
                return r;
            end
            // counterclockwise angle folded into (-half, half]
            t = (-longint'(ang)) % FULL_TURN;
            if (t < 0)
                t += FULL_TURN;
            if (t > HALF_TURN)
                t -= FULL_TURN;
            x = (longint'(px) - longint'(cx)) * GAIN_COMP;
            y = (longint'(py) - longint'(cy)) * GAIN_COMP;
            // beyond a quarter turn: negate the vector, move by half a turn
            if (t > QUARTER_TURN)
            begin
                x = -x;
                y = -y;
                t -= HALF_TURN;
            end
            else if (t < -QUARTER_TURN)
            begin
                x = -x;
                y = -y;
                t += HALF_TURN;
            end
            z = t * 65536;
            for (int i = 0; i < STAGES && i < 32; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys;
                    y += xs;
                    z -= ATAN_Q24[i];
                end
                else
                begin
                    x += ys;
                    y -= xs;
                    z += ATAN_Q24[i];
                end
            end
            sx = toward_zero(x) + longint'(cx);
            sy = toward_zero(y) + longint'(cy);
            if (sx > C_MAX)
            begin
                sx    = C_MAX;
                r.sat = 1'b1;
            end
            if (sx < C_MIN)
            begin
                sx    = C_MIN;
                r.sat = 1'b1;
            end
            if (sy > C_MAX)
            begin
                sy    = C_MAX;
                r.sat = 1'b1;
            end
            if (sy < C_MIN)
            begin
                sy    = C_MIN;
                r.sat = 1'b1;
            end
            r.x = sx[COORD_W-1:0];
            r.y = sy[COORD_W-1:0];
            return r;
        endfunction

        function void note_point(logic [IN_W-1:0] beat);
            rot_result_t r;
            angle_t      ang;
            ang = beat[4*COORD_W +: ANGLE_BITS];
            r = rotate_about_pivot(beat[0 +: COORD_W], beat[COORD_W +: COORD_W],
                                   beat[2*COORD_W +: COORD_W], beat[3*COORD_W +: COORD_W],
                                   ang);
            points++;
            if (ang == 0)
                zero_turns++;
            if (r.sat)
                clamped++;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(logic [OUT_W-1:0] beat, logic flag);
            rot_result_t exp_r;
            coord_t      got_x;
            coord_t      got_y;
            got_x = beat[0 +: COORD_W];
            got_y = beat[COORD_W +: COORD_W];
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction: out_x %0d out_y %0d saturated %0b",
                       got_x, got_y, flag);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            compared++;
            if (got_x !== exp_r.x)
            begin
                $error("out_x: expected %0d, got %0d", exp_r.x, got_x);
                mismatches++;
            end
            if (got_y !== exp_r.y)
            begin
                $error("out_y: expected %0d, got %0d", exp_r.y, got_y);
                mismatches++;
            end
            if (flag !== exp_r.sat)
            begin
                $error("saturated: expected %0b, got %0b", exp_r.sat, flag);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    rotation_scoreboard sb;
    bit                 sink_stalls = 1'b1;
    int unsigned        sink_left   = 0;

    rotate_point_about_pivot_top #(
        .COORD_BITS    (COORD_W),
        .CORDIC_STAGES (STAGES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sink: random bursts of ready and stall while stalls are allowed
    always @(negedge clk)
    begin
        if (!sink_stalls)
            m_axis_tready <= 1'b1;
        else if (sink_left == 0)
        begin
            sink_left     <= $urandom_range(0, 11);
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
        else
            sink_left <= sink_left - 1;
    end

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_point(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Present one point and hold it until the transaction completes
    task automatic send_point(input longint px, input longint py, input longint cx,
                              input longint cy, input int ang);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-4*COORD_W-ANGLE_BITS){1'b0}}, angle_t'(ang),
                          coord_t'(cy), coord_t'(cx), coord_t'(py), coord_t'(px)};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Source idles with valid low and junk on the data bus
    task automatic source_pause(input int n);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= IN_W'({$urandom(), $urandom(), $urandom(), $urandom()});
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom());
    endfunction

    function automatic coord_t near_coord(coord_t base);
        return coord_t'(int'(base) + int'($urandom_range(0, 2000)) - 1000);
    endfunction

    function automatic angle_t any_angle();
        return angle_t'(int'($urandom_range(0, 2*FULL_TURN)) - FULL_TURN);
    endfunction

    // Includes the ends of the angle field, beyond one turn either way
    function automatic angle_t special_angle();
        int picks [0:17] = '{0, 1, -1, QUARTER_TURN, -QUARTER_TURN, QUARTER_TURN + 1,
                             -QUARTER_TURN - 1, HALF_TURN, -HALF_TURN, HALF_TURN + 1,
                             -HALF_TURN - 1, 3*QUARTER_TURN, -3*QUARTER_TURN,
                             FULL_TURN, -FULL_TURN, FULL_TURN - 1, -131072, 131071};
        return angle_t'(picks[$urandom_range(0, 17)]);
    endfunction

    // Stimulus
    initial
    begin
        coord_t     px, py, cx, cy;
        angle_t     ang;
        point_mix_t mix;
        int         pick;

        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero angle passes extremes straight through
        send_point(C_MAX, C_MIN, C_MIN, C_MAX, 0);
        send_point(C_MIN, C_MAX, C_MAX, C_MIN, 0);
        // Whole turns in both directions
        send_point(1000, -2000, 300, 400, FULL_TURN);
        send_point(-5000, 7000, -100, 50, -FULL_TURN);
        // Quarter turns and just past them
        send_point(12345, 678, 0, 0, QUARTER_TURN);
        send_point(12345, 678, 0, 0, -QUARTER_TURN);
        send_point(-4321, 9876, 11, -22, QUARTER_TURN + 1);
        send_point(-4321, 9876, 11, -22, -QUARTER_TURN - 1);
        // Half turns, and a reduction past half a turn
        send_point(100000, -200000, 5000, 5000, HALF_TURN);
        send_point(100000, -200000, 5000, 5000, -HALF_TURN);
        send_point(7, 3, 0, 0, HALF_TURN + 1);
        send_point(7, 3, 0, 0, -HALF_TURN - 1);
        send_point(250, -250, -10, 10, 3*QUARTER_TURN);
        // Smallest turns
        send_point(C_MAX, C_MAX, 0, 0, 1);
        send_point(C_MIN, C_MIN, 0, 0, -1);
        // Point on the pivot
        send_point(-777, 888, -777, 888, 12345);
        // Clamping on each side
        send_point(C_MAX, C_MAX, C_MIN, C_MIN, HALF_TURN);
        send_point(C_MIN, C_MIN, C_MAX, C_MAX, HALF_TURN);
        send_point(C_MAX, 0, 0, 0, 11520);
        send_point(C_MIN, 0, 0, 0, -11520);
        send_point(C_MAX, C_MIN, C_MIN, C_MAX, -QUARTER_TURN);
        // Unit vectors, for truncation toward zero
        send_point(1, 0, 0, 0, 7680);
        send_point(0, -1, 0, 0, -7680);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // No idling in a middle stretch and in the final part
            sink_stalls = (n < CALM_FROM) && !(n >= 600 && n < 800);
            if (n == 900)
                wait_for_results();

            pick = $urandom_range(0, 9);
            mix  = (pick < 4) ? MIX_WIDE : (pick < 7) ? MIX_NEAR :
                   (pick < 8) ? MIX_ZERO : (pick < 9) ? MIX_SPECIAL : MIX_EDGE;
            cx  = any_coord();
            cy  = any_coord();
            px  = any_coord();
            py  = any_coord();
            ang = any_angle();
            case (mix)
                MIX_NEAR:
                begin
                    px = near_coord(cx);
                    py = near_coord(cy);
                end
                MIX_ZERO:
                    ang = 0;
                MIX_SPECIAL:
                    ang = special_angle();
                MIX_EDGE:
                begin
                    cx = ($urandom_range(0, 1) != 0) ? near_coord(coord_t'(C_MAX - 1000))
                                                     : near_coord(coord_t'(C_MIN + 1000));
                    cy = ($urandom_range(0, 1) != 0) ? near_coord(coord_t'(C_MAX - 1000))
                                                     : near_coord(coord_t'(C_MIN + 1000));
                end
                default: ;
            endcase
            send_point(longint'(px), longint'(py), longint'(cx), longint'(cy), int'(ang));
            if (sink_stalls && $urandom_range(0, 5) == 0)
                source_pause($urandom_range(1, 12));
        end

        // Drain, then wait for stray results
        sink_stalls = 1'b0;
        wait_for_results();
        repeat (LATENCY + 10)
            @(posedge clk);

        $display("Rotated %0d points (%0d with zero angle, %0d clamped), %0d results compared.",
                 sb.points, sb.zero_turns, sb.clamped, sb.compared);
        $display("Covered extremes, quarter and half turns, whole turns, random gaps and stalls.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rpap_pkg.sv
rtl/core/rpap_prep.sv
rtl/core/rpap_cell.sv
rtl/core/rpap_out.sv
rtl/core/rotate_point_about_pivot_top.sv
test/rotate_point_about_pivot_top_tb.sv
